FILE: design/tccw_pkg.sv
// shared constants, types and helpers for the text console cell writer
package tccw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int NUM_CELLS = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(NUM_CELLS);
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int CELL_W    = 16;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] BLANK_CHAR   = 8'd32;
    localparam logic [7:0] BLANK_COLOR  = 8'h0A;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CELL_W-1:0] cell_t;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR
    } state_t;

    localparam cell_t BLANK_CELL = {BLANK_COLOR, BLANK_CHAR};

    // linear cell address, row major
    function automatic addr_t cell_addr(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col);
        addr_t row_base;
        row_base = addr_t'(row) * addr_t'(COLUMNS);
        return row_base + addr_t'(col);
    endfunction

endpackage

FILE: design/tccw_ram.sv
// generic single write port, single read port ram with registered read
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/text_console_cell_writer_core.sv
// text console cell store with cursor, scroll, clear and cell read
//
//  channel   | ports                                      | transfer
//  ----------+--------------------------------------------+--------------------------
//  command   | start, busy, op, ch, read_row, read_col    | start high while busy low
//  result    | done, cursor_row_now, cursor_col_now,      | done high, one cycle,
//            | cell_char, cell_color, scrolled            | cannot be held off
//  register  | draw_color_we, draw_color                  | draw_color_we high
//
// put-char, newline without scroll, out-of-screen read and unused op: result next
// cycle, next command the cycle after acceptance.
// read inside the screen: the result passes the registered ram read, then the ST_READ state.
// scroll: result next cycle, then busy while rows are copied
// one cell a cycle through the ram and the bottom row is blanked.
// clear: result next cycle, then busy while every cell is blanked.
// after reset the ram is blanked in one pass over every cell with busy high.
module text_console_cell_writer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    op,
    input  logic [7:0]                    ch,
    input  logic [tccw_pkg::ROW_W-1:0]    read_row,
    input  logic [tccw_pkg::COL_W-1:0]    read_col,
    input  logic                          draw_color_we,
    input  logic [7:0]                    draw_color,
    output logic                          done,
    output logic [tccw_pkg::ROW_W-1:0]    cursor_row_now,
    output logic [tccw_pkg::COL_W-1:0]    cursor_col_now,
    output logic [7:0]                    cell_char,
    output logic [7:0]                    cell_color,
    output logic                          scrolled
);

    tccw_pkg::state_t               state_reg, state_next;
    tccw_pkg::addr_t                cnt_reg, cnt_next;
    logic                           pend_reg, pend_next;
    tccw_pkg::addr_t                pend_addr_reg, pend_addr_next;
    logic [tccw_pkg::ROW_W-1:0]     cur_row_reg, cur_row_next;
    logic [tccw_pkg::COL_W-1:0]     cur_col_reg, cur_col_next;
    logic [7:0]                     color_reg;
    logic                           done_reg, done_next;
    logic [tccw_pkg::ROW_W-1:0]     out_row_reg, out_row_next;
    logic [tccw_pkg::COL_W-1:0]     out_col_reg, out_col_next;
    logic [7:0]                     out_char_reg, out_char_next;
    logic [7:0]                     out_color_reg, out_color_next;
    logic                           out_scr_reg, out_scr_next;

    logic                           ram_we;
    tccw_pkg::addr_t                ram_waddr, ram_raddr;
    tccw_pkg::cell_t                ram_wdata, ram_rdata;

    logic                           accept;
    logic                           row_last, col_last, read_in_range, cnt_last;
    tccw_pkg::op_t                  op_code;

    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (tccw_pkg::NUM_CELLS)
    ) u_screen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy          = (state_reg != tccw_pkg::ST_IDLE);
    assign accept        = start && !busy;
    assign op_code       = tccw_pkg::op_t'(op);
    assign row_last      = (32'(cur_row_reg) == tccw_pkg::ROWS - 1);
    assign col_last      = (32'(cur_col_reg) == tccw_pkg::COLUMNS - 1);
    assign read_in_range = (32'(read_row) < tccw_pkg::ROWS)
                        && (32'(read_col) < tccw_pkg::COLUMNS);
    assign cnt_last      = (32'(cnt_reg) == tccw_pkg::NUM_CELLS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tccw_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            color_reg     <= tccw_pkg::BLANK_COLOR;
            done_reg      <= 1'b0;
            out_scr_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            done_reg    <= done_next;
            out_scr_reg <= out_scr_next;
            if (draw_color_we)
            begin
                color_reg <= draw_color;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_char_reg  <= out_char_next;
        out_color_reg <= out_color_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        done_next      = 1'b0;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_char_next  = 8'd0;
        out_color_next = 8'd0;
        out_scr_next   = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg;
        ram_wdata      = tccw_pkg::BLANK_CELL;
        ram_raddr      = cnt_reg;

        case (state_reg)
            tccw_pkg::ST_IDLE:
            begin
                ram_raddr = read_in_range ? tccw_pkg::cell_addr(read_row, read_col) : '0;
                if (accept)
                begin
                    case (op_code)
                        tccw_pkg::OP_PUT:
                        begin
                            if (ch != tccw_pkg::NEWLINE_CHAR)
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = tccw_pkg::cell_addr(cur_row_reg, cur_col_reg);
                                ram_wdata    = {color_reg, ch};
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                            if (ch == tccw_pkg::NEWLINE_CHAR || col_last)
                            begin
                                cur_col_next = '0;
                                if (row_last)
                                begin
                                    // cursor lands on the bottom row; copy starts at row one
                                    cur_row_next = tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1);
                                    out_scr_next = 1'b1;
                                    cnt_next     = tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
                                    state_next   = tccw_pkg::ST_SCROLL;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                end
                            end
                            done_next = 1'b1;
                        end
                        tccw_pkg::OP_CLEAR:
                        begin
                            cur_row_next = '0;
                            cur_col_next = '0;
                            cnt_next     = '0;
                            state_next   = tccw_pkg::ST_CLEAR;
                            done_next    = 1'b1;
                        end
                        tccw_pkg::OP_READ:
                        begin
                            if (read_in_range)
                            begin
                                state_next = tccw_pkg::ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                    out_row_next = cur_row_next;
                    out_col_next = cur_col_next;
                end
            end
            tccw_pkg::ST_READ:
            begin
                done_next      = 1'b1;
                out_row_next   = cur_row_reg;
                out_col_next   = cur_col_reg;
                out_char_next  = ram_rdata[7:0];
                out_color_next = ram_rdata[15:8];
                state_next     = tccw_pkg::ST_IDLE;
            end
            tccw_pkg::ST_SCROLL:
            begin
                // read one row ahead, write the cell read in the previous cycle
                ram_raddr      = cnt_reg;
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg - tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
                ram_we         = pend_reg;
                ram_waddr      = pend_addr_reg;
                ram_wdata      = ram_rdata;
                if (cnt_last)
                begin
                    cnt_next   = tccw_pkg::ADDR_W'(tccw_pkg::NUM_CELLS - tccw_pkg::COLUMNS);
                    state_next = tccw_pkg::ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tccw_pkg::ST_BLANK:
            begin
                ram_we = 1'b1;
                if (pend_reg)
                begin
                    // last copied cell drains before the bottom row is blanked
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                else
                begin
                    if (cnt_last)
                    begin
                        state_next = tccw_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            tccw_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (cnt_last)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = tccw_pkg::ST_IDLE;
            end
        endcase
    end

    assign done           = done_reg;
    assign cursor_row_now = out_row_reg;
    assign cursor_col_now = out_col_reg;
    assign cell_char      = out_char_reg;
    assign cell_color     = out_color_reg;
    assign scrolled       = out_scr_reg;

    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op != tccw_pkg::OP_READ) |=> done)
        else $error("no result after a non-read transfer");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tccw_pkg::ST_READ) |=> (done && state_reg == tccw_pkg::ST_IDLE))
        else $error("read result not delivered");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        scrolled |-> (done && 32'(cursor_row_now) == tccw_pkg::ROWS - 1
                      && cursor_col_now == '0 && state_reg == tccw_pkg::ST_SCROLL))
        else $error("scroll result inconsistent");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_row_reg) < tccw_pkg::ROWS) && (32'(cur_col_reg) < tccw_pkg::COLUMNS))
        else $error("cursor outside the screen");

    a_no_pend_outside_copy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ($past(state_reg) == tccw_pkg::ST_SCROLL))
        else $error("pending copy write outside scroll");

endmodule
